[sv/hsrd_pkg.sv]
`default_nettype none
package hsrd_pkg;

	localparam int unsigned DivWidth = 24;
	localparam int unsigned DsrWidth = 16;
	localparam int unsigned StepWidth = 5;

	typedef struct packed {
		logic                 start;
		logic [DsrWidth-1:0]  rem_init;
		logic [DivWidth-1:0]  dividend;
		logic [DsrWidth-1:0]  divisor;
		logic [StepWidth-1:0] steps;
	} div_cmd_t;

endpackage
`default_nettype wire

[sv/hall_sensor_rotor_decoder_unit.sv]
`default_nettype none
// Hall sensor rotor decoder. Each input request is one prescaled timer tick carrying the
// sampled hall pattern in s_tdata[2:0]; each produces exactly one result. While the rotor
// moves and the tick count is still inside the last period, a request passes through the
// accept step, a multiply step, a 16-step restoring division for the interpolated angle
// and a 24-step division for the speed, both on one shared divider, with the angle, speed
// and output sequencing steps between them. Once the count reaches the period the angle
// division is skipped; when stopped or with a zero period both are skipped. The next
// request is taken once the result is loaded into the output register, where it may still
// wait; a result not yet taken holds the following one at its last step. tick_rate is
// written through cfg_wen/cfg_wdata; the user must write it only while idle, which the
// block itself does not enforce.
module hall_sensor_rotor_decoder_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_wen,
	input  wire logic [23:0]  cfg_wdata,     // tick_rate
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [7:0]   s_tdata,       // [2:0] hall_pattern
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// [2:0] hall_state, [3] changed, [5:4] direction, [22:6] sector_angle,
	// [40:23] interpolated_angle, [64:41] speed, [80:65] period, [112:81] turns
	output logic [119:0]      m_tdata
);
	import hsrd_pkg::*;

	localparam int unsigned TIMER_MAX    = 65535;
	localparam int unsigned SECTOR_UNITS = 15360;
	localparam logic [23:0] SPEED_SAT    = 24'hFFFFFF;

	localparam logic [1:0] DIR_STOP = 2'd0;
	localparam logic [1:0] DIR_FWD  = 2'd1;
	localparam logic [1:0] DIR_REV  = 2'd2;

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_MUL      = 3'd1;
	localparam logic [2:0] ST_ANG_GO   = 3'd2;
	localparam logic [2:0] ST_ANG_WAIT = 3'd3;
	localparam logic [2:0] ST_SPD_GO   = 3'd4;
	localparam logic [2:0] ST_SPD_WAIT = 3'd5;
	localparam logic [2:0] ST_OUT      = 3'd6;

	localparam logic [2:0] PAT_RESET = 3'b000;
	localparam logic [2:0] PAT_A     = 3'b001;
	localparam logic [2:0] PAT_B     = 3'b101;

	// forward successor (8 = outside the cycle) and sector index entered going forward,
	// listed from pattern 7 down to pattern 0
	localparam logic [7:0][3:0] FWD_NEXT  = {4'd8, 4'd2, 4'd4, 4'd6, 4'd1, 4'd3, 4'd5, 4'd8};
	localparam logic [7:0][2:0] SECTOR_OF = {3'd0, 3'd2, 3'd0, 3'd1, 3'd4, 3'd3, 3'd5, 3'd0};

	logic [2:0]  state_q;
	logic [23:0] tick_rate_q;
	logic [2:0]  pat_q;
	logic [16:0] sect_q;
	logic [1:0]  dir_q;
	logic [15:0] cnt_q;
	logic [15:0] period_q;
	logic [31:0] turns_q;
	logic        changed_q;
	logic [31:0] prod_q;
	logic [15:0] moved_q;
	logic [23:0] speed_q;

	logic        acc;
	logic [2:0]  nxt;
	logic        take;
	logic [1:0]  t_dir;
	logic [2:0]  t_idx;
	logic [18:0] ang_full;
	logic        moving;
	logic        per_zero;
	logic        need_ang;
	logic        out_load;
	logic [17:0] interp;
	div_cmd_t    div_cmd;
	logic        div_done;
	logic [DivWidth-1:0] div_quo;

	assign s_tready = (state_q == ST_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign nxt      = s_tdata[2:0];
	assign out_load = (state_q == ST_OUT) && (!m_tvalid || m_tready);

	always_comb begin
		take  = 1'b0;
		t_dir = DIR_STOP;
		t_idx = '0;
		if (nxt != pat_q) begin
			if (pat_q == PAT_RESET) begin
				take = 1'b1;
			end else if (FWD_NEXT[pat_q] == {1'b0, nxt}) begin
				take  = 1'b1;
				t_dir = DIR_FWD;
				t_idx = SECTOR_OF[nxt];
			end else if (FWD_NEXT[nxt] == {1'b0, pat_q}) begin
				take  = 1'b1;
				t_dir = DIR_REV;
				t_idx = SECTOR_OF[pat_q];
			end
		end
	end

	assign ang_full = 19'(t_idx) * 19'(SECTOR_UNITS);

	assign moving   = (dir_q == DIR_FWD) || (dir_q == DIR_REV);
	assign per_zero = (period_q == '0);
	assign need_ang = moving && !per_zero && (cnt_q < period_q);

	always_comb begin
		div_cmd          = '0;
		div_cmd.divisor  = period_q;
		if (state_q == ST_ANG_GO) begin
			div_cmd.start    = need_ang;
			div_cmd.rem_init = prod_q[31:16];
			div_cmd.dividend = {prod_q[15:0], 8'd0};
			div_cmd.steps    = StepWidth'(16);
		end else if (state_q == ST_SPD_GO) begin
			div_cmd.start    = moving && !per_zero;
			div_cmd.dividend = tick_rate_q;
			div_cmd.steps    = StepWidth'(DivWidth);
		end
	end

	hsrd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (div_cmd),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		case (dir_q)
			DIR_FWD: interp = 18'(sect_q) + 18'(moved_q);
			DIR_REV: interp = 18'(sect_q) - 18'(moved_q);
			default: interp = 18'(sect_q);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_rate_q <= 24'd1093733;
		end else if (cfg_wen) begin
			tick_rate_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pat_q     <= '0;
			sect_q    <= '0;
			dir_q     <= DIR_STOP;
			cnt_q     <= '0;
			period_q  <= '0;
			turns_q   <= '0;
			changed_q <= 1'b0;
			m_tvalid  <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						changed_q <= take;
						if (take) begin
							pat_q    <= nxt;
							sect_q   <= ang_full[16:0];
							dir_q    <= t_dir;
							period_q <= cnt_q;
							cnt_q    <= '0;
							if (pat_q == PAT_A && nxt == PAT_B) begin
								turns_q <= turns_q + 32'd1;
							end else if (pat_q == PAT_B && nxt == PAT_A) begin
								turns_q <= turns_q - 32'd1;
							end
						end else if (cnt_q >= 16'(TIMER_MAX)) begin
							cnt_q <= '0;
							dir_q <= DIR_STOP;
						end else begin
							cnt_q <= cnt_q + 16'd1;
						end
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_ANG_GO;
				end
				ST_ANG_GO: begin
					state_q <= need_ang ? ST_ANG_WAIT : ST_SPD_GO;
				end
				ST_ANG_WAIT: begin
					if (div_done) begin
						state_q <= ST_SPD_GO;
					end
				end
				ST_SPD_GO: begin
					state_q <= (moving && !per_zero) ? ST_SPD_WAIT : ST_OUT;
				end
				ST_SPD_WAIT: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			prod_q <= 32'(cnt_q) * 32'(SECTOR_UNITS);
		end
		if (state_q == ST_ANG_GO && !need_ang) begin
			moved_q <= moving ? 16'(SECTOR_UNITS) : 16'd0;
		end
		if (state_q == ST_ANG_WAIT && div_done) begin
			moved_q <= div_quo[15:0];
		end
		if (state_q == ST_SPD_GO && !(moving && !per_zero)) begin
			speed_q <= moving ? SPEED_SAT : 24'd0;
		end
		if (state_q == ST_SPD_WAIT && div_done) begin
			speed_q <= div_quo;
		end
		if (out_load) begin
			m_tdata <= {7'd0, turns_q, period_q, speed_q, interp, sect_q, dir_q, changed_q,
				pat_q};
		end
	end

	a_acc_to_mul: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> (state_q == ST_MUL))
		else $error("accepted request did not start the sequence");

	a_rose_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> ($past(state_q) == ST_OUT))
		else $error("result shown outside the output step");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_ANG_WAIT || state_q == ST_SPD_WAIT))
		else $error("divider finished with no division pending");

	a_period_held: assert property (@(posedge clk) disable iff (!arst_n)
		!acc |=> $stable(period_q))
		else $error("period changed without a request");

endmodule
`default_nettype wire

[sv/hsrd_div.sv]
`default_nettype none
module hsrd_div (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire hsrd_pkg::div_cmd_t                  cmd,
	output logic                                     done,
	output logic [hsrd_pkg::DivWidth-1:0]            quotient
);
	import hsrd_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [StepWidth-1:0] cnt_q;
	logic [DsrWidth-1:0]  rem_q;
	logic [DsrWidth-1:0]  dsr_q;
	logic [DivWidth-1:0]  num_q;
	logic [DsrWidth:0]    trial;
	logic [DsrWidth:0]    diff;
	logic                 ge;

	// restoring step, one quotient bit per cycle
	assign trial = {rem_q, num_q[DivWidth-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign ge    = (trial >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= cmd.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - StepWidth'(1);
				if (cnt_q == StepWidth'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q <= cmd.rem_init;
			num_q <= cmd.dividend;
			dsr_q <= cmd.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DsrWidth-1:0] : trial[DsrWidth-1:0];
			num_q <= {num_q[DivWidth-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = num_q;

endmodule
`default_nettype wire

[tb/sv/tb_hall_sensor_rotor_decoder_unit.sv]
`timescale 1ns / 1ps

module tb_hall_sensor_rotor_decoder_unit;

	localparam int unsigned TIMER_MAX    = 65535;
	localparam int unsigned SECTOR_UNITS = 15360;
	localparam int          NOT_IN_CYCLE = 6;
	localparam int          CYCLE_LIMIT  = 1000000;
	localparam int          STALL_CYCLES = 600;
	localparam int          PRINT_CAP    = 40;
	localparam logic [23:0] RATE_MAX     = 24'hFFFFFF;
	localparam logic [23:0] RATE_DEFAULT = 24'd1093733;
	localparam logic [2:0]  HALL_RESET   = 3'b000;
	localparam logic [2:0]  TURN_LO      = 3'b001;
	localparam logic [2:0]  TURN_HI      = 3'b101;

	// opening sequence from reset, first tick in the top bits
	localparam logic [74:0] OPENING = {
		3'b000, 3'b000, 3'b110, 3'b010, 3'b010, 3'b010, 3'b011, 3'b001, 3'b101,
		3'b101, 3'b001, 3'b101, 3'b001, 3'b011, 3'b111, 3'b000, 3'b100, 3'b010,
		3'b110, 3'b100, 3'b101, 3'b001, 3'b001, 3'b011, 3'b010
	};

	typedef enum logic [1:0] {
		DIR_STOP = 2'd0,
		DIR_FWD  = 2'd1,
		DIR_REV  = 2'd2
	} rotor_dir_t;

	typedef struct packed {
		logic [31:0] turns;
		logic [15:0] period;
		logic [23:0] speed;
		logic [17:0] interp_angle;
		logic [16:0] sector_angle;
		logic [1:0]  direction;
		logic        changed;
		logic [2:0]  hall_state;
	} rotor_result_t;

	logic         clk;
	logic         arst_n    = 1'b0;
	logic         cfg_wen   = 1'b0;
	logic [23:0]  cfg_wdata = '0;
	logic         s_tvalid  = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata   = '0;
	logic         m_tvalid;
	logic         m_tready  = 1'b0;
	logic [119:0] m_tdata;

	// decoder state as the checker sees it
	logic [2:0]  rot_pat    = HALL_RESET;
	logic [16:0] rot_sector = '0;
	rotor_dir_t  rot_dir    = DIR_STOP;
	logic [15:0] rot_ticks  = '0;
	logic [15:0] rot_period = '0;
	logic [31:0] rot_turns  = '0;
	logic [23:0] rot_rate   = RATE_DEFAULT;

	logic [2:0]    hall_tick_q[$];
	rotor_result_t decoder_out_q[$];
	rotor_result_t seen_res, want_res;

	logic [2:0] gen_pat = HALL_RESET;
	logic       gen_fwd = 1'b1;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int stall_req = 0;
	int stall_ack = 0;
	int stall_left = 0;
	int cycle_count = 0;
	int mismatches = 0;
	int ticks_queued = 0;
	int transitions = 0;
	int results_checked = 0;

	hall_sensor_rotor_decoder_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int cycle_pos(input logic [2:0] p);
		case (p)
			3'b101: return 0;
			3'b100: return 1;
			3'b110: return 2;
			3'b010: return 3;
			3'b011: return 4;
			3'b001: return 5;
			default: return NOT_IN_CYCLE;
		endcase
	endfunction

	function automatic logic [2:0] cycle_pat(input int pos);
		case (pos)
			0: return 3'b101;
			1: return 3'b100;
			2: return 3'b110;
			3: return 3'b010;
			4: return 3'b011;
			default: return 3'b001;
		endcase
	endfunction

	// forward and reverse steps take the sector of the forward target
	function automatic logic classify_move(input logic [2:0] cur, input logic [2:0] nxt,
			output rotor_dir_t d, output int unsigned ang);
		int ci, ni;
		d = DIR_STOP;
		ang = 0;
		ci = cycle_pos(cur);
		ni = cycle_pos(nxt);
		if (nxt == cur)
			return 1'b0;
		if (cur == HALL_RESET)
			return 1'b1;
		if (ci == NOT_IN_CYCLE || ni == NOT_IN_CYCLE)
			return 1'b0;
		if (ni == (ci + 1) % 6) begin
			d = DIR_FWD;
			ang = ni;
			return 1'b1;
		end
		if (ci == (ni + 1) % 6) begin
			d = DIR_REV;
			ang = ci;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic rotor_result_t advance_rotor(input logic [2:0] pat);
		rotor_result_t r;
		rotor_dir_t mv_dir;
		int unsigned ang;
		logic taken;
		logic [2:0] from;
		longint moved;
		int interp;
		logic [23:0] speed;
		from = rot_pat;
		taken = classify_move(rot_pat, pat, mv_dir, ang);
		if (taken) begin
			rot_pat = pat;
			rot_sector = 17'(ang * SECTOR_UNITS);
			rot_dir = mv_dir;
			rot_period = rot_ticks;
			rot_ticks = '0;
			if (from == TURN_LO && pat == TURN_HI)
				rot_turns = rot_turns + 1;
			else if (from == TURN_HI && pat == TURN_LO)
				rot_turns = rot_turns - 1;
			transitions++;
		end else if (rot_ticks >= TIMER_MAX) begin
			rot_ticks = '0;
			rot_dir = DIR_STOP;
		end else begin
			rot_ticks = rot_ticks + 1;
		end
		interp = rot_sector;
		speed = '0;
		if (rot_dir != DIR_STOP) begin
			if (rot_period == 0) begin
				moved = SECTOR_UNITS;
				speed = RATE_MAX;
			end else begin
				moved = (longint'(rot_ticks) * SECTOR_UNITS) / rot_period;
				if (moved > SECTOR_UNITS)
					moved = SECTOR_UNITS;
				speed = rot_rate / rot_period;
			end
			if (rot_dir == DIR_FWD)
				interp = interp + int'(moved);
			else
				interp = interp - int'(moved);
		end
		r.hall_state = rot_pat;
		r.changed = taken;
		r.direction = rot_dir;
		r.sector_angle = rot_sector;
		r.interp_angle = interp[17:0];
		r.speed = speed;
		r.period = rot_period;
		r.turns = rot_turns;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < PRINT_CAP)
			$display("%0t: %s mismatch, got 0x%0h expected 0x%0h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic push_tick(input logic [2:0] p);
		rotor_dir_t d;
		int unsigned a;
		hall_tick_q.push_back(p);
		if (classify_move(gen_pat, p, d, a))
			gen_pat = p;
		ticks_queued++;
	endtask

	// mostly legal rotation with dwell, plus noise and skipped sectors
	task automatic queue_random_ticks(input int n);
		int left, r, k, pos;
		left = n;
		while (left > 0) begin
			r = $urandom_range(99);
			pos = cycle_pos(gen_pat);
			if (r < 60) begin
				if ($urandom_range(9) < 2)
					gen_fwd = ~gen_fwd;
				push_tick(cycle_pat(gen_fwd ? (pos + 1) % 6 : (pos + 5) % 6));
				left--;
				k = ($urandom_range(99) < 4) ? $urandom_range(200, 20) : $urandom_range(4);
				while (k > 0 && left > 0) begin
					push_tick(gen_pat);
					k--;
					left--;
				end
			end else if (r < 75) begin
				push_tick(gen_pat);
				left--;
			end else if (r < 90) begin
				push_tick(3'($urandom_range(7)));
				left--;
			end else begin
				push_tick(cycle_pat((pos + 2 + $urandom_range(2)) % 6));
				left--;
			end
		end
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (hall_tick_q.size() != 0 || s_tvalid || decoder_out_q.size() != 0);
	endtask

	task automatic write_tick_rate(input logic [23:0] v);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen <= 1'b0;
		rot_rate = v;
		@(negedge clk);
	endtask

	// request driver and predictor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready)
				decoder_out_q.push_back(advance_rotor(s_tdata[2:0]));
			if (!s_tvalid || s_tready) begin
				if (hall_tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata <= {5'b0, hall_tick_q.pop_front()};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_left <= 0;
			stall_ack <= 0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (stall_ack != stall_req) begin
			stall_left <= STALL_CYCLES;
			stall_ack <= stall_req;
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen_res = m_tdata[112:0];
				if (decoder_out_q.size() == 0) begin
					report_mismatch("unexpected result", seen_res.hall_state, '0);
				end else begin
					want_res = decoder_out_q.pop_front();
					if (seen_res.hall_state !== want_res.hall_state)
						report_mismatch("hall_state", seen_res.hall_state, want_res.hall_state);
					if (seen_res.changed !== want_res.changed)
						report_mismatch("changed", seen_res.changed, want_res.changed);
					if (seen_res.direction !== want_res.direction)
						report_mismatch("direction", seen_res.direction, want_res.direction);
					if (seen_res.sector_angle !== want_res.sector_angle)
						report_mismatch("sector_angle", seen_res.sector_angle,
							want_res.sector_angle);
					if (seen_res.interp_angle !== want_res.interp_angle)
						report_mismatch("interpolated_angle", seen_res.interp_angle,
							want_res.interp_angle);
					if (seen_res.speed !== want_res.speed)
						report_mismatch("speed", seen_res.speed, want_res.speed);
					if (seen_res.period !== want_res.period)
						report_mismatch("period", seen_res.period, want_res.period);
					if (seen_res.turns !== want_res.turns)
						report_mismatch("turns", seen_res.turns, want_res.turns);
				end
				results_checked++;
			end
			if (stall_left != 0)
				m_tready <= 1'b0;
			else
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 34;
		recv_idle_pct = 52;
		write_tick_rate(RATE_MAX);
		for (int i = 24; i >= 0; i--)
			push_tick(OPENING[3*i +: 3]);
		wait_drained();

		write_tick_rate(24'd1);
		queue_random_ticks(400);
		wait_drained();

		send_idle_pct = 52;
		recv_idle_pct = 34;
		write_tick_rate(24'($urandom_range(RATE_MAX, 2)));
		queue_random_ticks(400);
		wait_drained();

		// long output hold-off while ticks keep coming
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_tick_rate(24'($urandom_range(1000, 1)));
		queue_random_ticks(60);
		stall_req++;
		queue_random_ticks(340);
		wait_drained();

		// sender pauses mid-stream until all results are back
		write_tick_rate(RATE_DEFAULT);
		queue_random_ticks(200);
		wait_drained();
		queue_random_ticks(200);
		wait_drained();

		repeat (100) @(posedge clk);
		$display("Sent %0d hall ticks (%0d accepted transitions, final turn count %0d)",
			ticks_queued, transitions, $signed(rot_turns));
		$display("Checked %0d results across five tick_rate settings, %0d mismatches",
			results_checked, mismatches);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

[sim.f]
sv/hsrd_pkg.sv
sv/hsrd_div.sv
sv/hall_sensor_rotor_decoder_unit.sv
tb/sv/tb_hall_sensor_rotor_decoder_unit.sv
